// ===== hdl/gbcy_pkg.sv =====
`default_nettype none
package gbcy_pkg;

  localparam int unsigned CAL_SAMPLES = 256;
  localparam int unsigned CAL_LOG2    = $clog2(CAL_SAMPLES);
  localparam int unsigned CNT_W       = 13;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BIAS_W   = 24;
  localparam int unsigned SUM_W    = 28;
  localparam int unsigned RATE_W   = 25;
  localparam int unsigned YAW_W    = 56;
  localparam int unsigned DB_W     = 15;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned PROD_W   = RATE_W + GAIN_W + 1;
  localparam int unsigned DELTA_W  = PROD_W - 8;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN = 4'd1;

  localparam logic [DB_W-1:0]   DEADBAND_RST = 15'd10;
  localparam logic [GAIN_W-1:0] YAW_GAIN_RST = 16'd5866;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 136;

  typedef struct packed {
    logic load;
    logic cal_active;
    logic cal_done;
  } lane_ctl_t;

  typedef struct packed {
    logic b_load;
    logic c_load;
  } merge_ctl_t;

endpackage
`default_nettype wire

// ===== hdl/gyro_bias_calibrate_yaw_integrate.sv =====
// Gyro bias calibration and yaw integration.
// Input stream (s_*): one three-axis raw gyro sample per beat, tdata holds
// x, y, z as signed 16-bit values. Output stream (m_*): one result per input
// beat with corrected rates (8 fractional bits), the integrated yaw in
// 2^-24 degree units and a calibrated flag in tuser.
// Configuration channel (cfg_*): index 0 writes the z deadband, index 1 the
// yaw gain; other indexes are dropped. cfg_ready is always high. Write only
// while no sample is in flight.
// Three axis lanes correct and average the sample in the cycle it is taken;
// a merge stage applies the deadband, multiplies by the gain and updates the
// yaw accumulator. Each result passes the lane registers, stage B and stage C,
// and one sample is taken every cycle as long as the output is drained.
// Reset clears the bias, the sums and the yaw and restarts calibration; the
// first 256 samples are averaged into the bias, which applies from the next
// sample on.
// When m_tready is low the result is held and the three pipeline stages
// fill up before s_tready drops.
`default_nettype none
module gyro_bias_calibrate_yaw_integrate (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // rate_x_sample[15:0], rate_y_sample[31:16], rate_z_sample[47:32]
  input  wire logic [gbcy_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // yaw_angle[55:0], rate_x_corrected[80:56], rate_y_corrected[105:81],
  // rate_z_corrected[130:106], zero pad [135:131]
  output logic [gbcy_pkg::OUT_DATA_W-1:0]          m_tdata,
  // calibrated[0]
  output logic                                     m_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [gbcy_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gbcy_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [gbcy_pkg::DB_W-1:0]   deadband;
  logic [gbcy_pkg::GAIN_W-1:0] yaw_gain;

  logic                        a_valid, b_valid, c_valid;
  logic                        a_ready, b_ready, c_ready;
  logic                        a_load;
  logic [gbcy_pkg::CNT_W-1:0]  sample_count;
  logic [gbcy_pkg::CNT_W-1:0]  sample_count_next;
  logic                        calibrating;
  logic                        cal_a, cal_b, cal_c;

  gbcy_pkg::lane_ctl_t         lane_ctl;
  gbcy_pkg::merge_ctl_t        merge_ctl;

  logic signed [gbcy_pkg::RATE_W-1:0] corr_x, corr_y, corr_z;
  logic signed [gbcy_pkg::RATE_W-1:0] corr_x_b, corr_y_b;
  logic signed [gbcy_pkg::RATE_W-1:0] corr_x_c, corr_y_c, corr_z_c;
  logic signed [gbcy_pkg::YAW_W-1:0]  yaw_angle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= gbcy_pkg::DEADBAND_RST;
      yaw_gain <= gbcy_pkg::YAW_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gbcy_pkg::REG_DEADBAND: deadband <= cfg_data[gbcy_pkg::DB_W-1:0];
        gbcy_pkg::REG_YAW_GAIN: yaw_gain <= cfg_data[gbcy_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake: each stage advances when the one after it has room
  assign c_ready  = !c_valid || m_tready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;
  assign a_load   = s_tvalid && a_ready;

  assign merge_ctl.b_load = a_valid && b_ready;
  assign merge_ctl.c_load = b_valid && c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid <= 1'b1;
      end else if (merge_ctl.b_load) begin
        a_valid <= 1'b0;
      end
      if (merge_ctl.b_load) begin
        b_valid <= 1'b1;
      end else if (merge_ctl.c_load) begin
        b_valid <= 1'b0;
      end
      if (merge_ctl.c_load) begin
        c_valid <= 1'b1;
      end else if (m_tready) begin
        c_valid <= 1'b0;
      end
    end
  end

  assign sample_count_next = sample_count + gbcy_pkg::CNT_W'(1);

  assign lane_ctl.load       = a_load;
  assign lane_ctl.cal_active = calibrating;
  assign lane_ctl.cal_done   = calibrating &&
                               (sample_count_next >= gbcy_pkg::CNT_W'(gbcy_pkg::CAL_SAMPLES));

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      calibrating  <= 1'b1;
    end else if (a_load && calibrating) begin
      sample_count <= sample_count_next;
      if (lane_ctl.cal_done) begin
        calibrating <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      cal_a <= !calibrating || lane_ctl.cal_done;
    end
    if (merge_ctl.b_load) begin
      corr_x_b <= corr_x;
      corr_y_b <= corr_y;
      cal_b    <= cal_a;
    end
    if (merge_ctl.c_load) begin
      corr_x_c <= corr_x_b;
      corr_y_c <= corr_y_b;
      cal_c    <= cal_b;
    end
  end

  gbcy_axis_lane u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .sample    (s_tdata[15:0]),
    .corrected (corr_x)
  );

  gbcy_axis_lane u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .sample    (s_tdata[31:16]),
    .corrected (corr_y)
  );

  gbcy_axis_lane u_lane_z (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .sample    (s_tdata[47:32]),
    .corrected (corr_z)
  );

  gbcy_yaw_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctl        (merge_ctl),
    .deadband   (deadband),
    .yaw_gain   (yaw_gain),
    .rate_z     (corr_z),
    .rate_z_out (corr_z_c),
    .yaw_angle  (yaw_angle)
  );

  assign m_tvalid = c_valid;
  assign m_tdata  = {5'b0, corr_z_c, corr_y_c, corr_x_c, yaw_angle};
  assign m_tuser  = cal_c;

`ifndef SYNTHESIS
  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    !calibrating |=> !calibrating)
    else $error("calibration restarted without reset");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= gbcy_pkg::CNT_W'(gbcy_pkg::CAL_SAMPLES))
    else $error("sample count ran past calibration length");

  a_cal_end: assert property (@(posedge clk) disable iff (rst)
    !calibrating |-> sample_count == gbcy_pkg::CNT_W'(gbcy_pkg::CAL_SAMPLES))
    else $error("calibration ended at wrong count");

  a_out_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser && m_tready) |-> !calibrating)
    else $error("calibrated flag leaves while still calibrating");
`endif

endmodule
`default_nettype wire

// ===== hdl/gbcy_axis_lane.sv =====
`default_nettype none
module gbcy_axis_lane (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire gbcy_pkg::lane_ctl_t                   ctl,
  input  wire logic signed [gbcy_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [gbcy_pkg::RATE_W-1:0]         corrected
);

  localparam int unsigned WIDE_W = gbcy_pkg::SUM_W + 8;

  logic signed [gbcy_pkg::BIAS_W-1:0] bias;
  logic signed [gbcy_pkg::SUM_W-1:0]  sum;
  logic signed [gbcy_pkg::SUM_W-1:0]  sum_next;
  logic signed [WIDE_W-1:0]           avg_wide;
  logic signed [gbcy_pkg::RATE_W-1:0] scaled;

  assign sum_next = sum + gbcy_pkg::SUM_W'(sample);
  // floor(sum * 256 / N) with N a power of two
  assign avg_wide = $signed({sum_next, 8'b0}) >>> gbcy_pkg::CAL_LOG2;
  assign scaled   = $signed({sample[gbcy_pkg::SAMPLE_W-1], sample, 8'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      bias <= '0;
    end else if (ctl.load && ctl.cal_active) begin
      sum <= sum_next;
      if (ctl.cal_done) begin
        bias <= avg_wide[gbcy_pkg::BIAS_W-1:0];
      end
    end
  end

  // correction uses the bias in force before this beat
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      corrected <= scaled - gbcy_pkg::RATE_W'(bias);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/gbcy_yaw_merge.sv =====
`default_nettype none
module gbcy_yaw_merge (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire gbcy_pkg::merge_ctl_t                 ctl,
  input  wire logic [gbcy_pkg::DB_W-1:0]            deadband,
  input  wire logic [gbcy_pkg::GAIN_W-1:0]          yaw_gain,
  input  wire logic signed [gbcy_pkg::RATE_W-1:0]   rate_z,
  output logic signed [gbcy_pkg::RATE_W-1:0]        rate_z_out,
  output logic signed [gbcy_pkg::YAW_W-1:0]         yaw_angle
);

  logic signed [gbcy_pkg::RATE_W-1:0]  thr_pos;
  logic signed [gbcy_pkg::RATE_W-1:0]  thr_neg;
  logic                                in_band;
  logic signed [gbcy_pkg::PROD_W-1:0]  prod;
  logic signed [gbcy_pkg::DELTA_W-1:0] delta;
  logic signed [gbcy_pkg::RATE_W-1:0]  rate_z_b;
  logic signed [gbcy_pkg::YAW_W-1:0]   yaw_next;

  assign thr_pos = $signed({2'b00, deadband, 8'b0});
  assign thr_neg = -thr_pos;
  assign in_band = (rate_z >= thr_pos) || (rate_z <= thr_neg);
  assign prod    = rate_z * $signed({1'b0, yaw_gain});

  // stage B: deadband and scale, arithmetic shift gives floor
  always_ff @(posedge clk) begin
    if (ctl.b_load) begin
      delta    <= in_band ? gbcy_pkg::DELTA_W'(prod >>> 8) : '0;
      rate_z_b <= in_band ? rate_z : '0;
    end
  end

  assign yaw_next = yaw_angle - gbcy_pkg::YAW_W'(delta);

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_angle <= '0;
    end else if (ctl.c_load) begin
      yaw_angle <= yaw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.c_load) begin
      rate_z_out <= rate_z_b;
    end
  end

endmodule
`default_nettype wire
